// ===== design/olid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and constants for the ordered list insert/delete core.
// ----------------------------------------------------------------------------
package olid_pkg;

	localparam int VALUE_W     = 32;
	localparam int POS_W       = 5;
	localparam int LEN_OUT_W   = 6;
	localparam int MAX_RESULTS = 32;

	typedef enum logic [3:0] {
		REQ_APPEND     = 4'd0,
		REQ_INSERT     = 4'd1,
		REQ_PREPEND    = 4'd2,
		REQ_DROP_FIRST = 4'd3,
		REQ_DROP_LAST  = 4'd4,
		REQ_DROP_AT    = 4'd5,
		REQ_DROP_VALUE = 4'd6,
		REQ_LOCATE     = 4'd7,
		REQ_DROP_RANGE = 4'd8,
		REQ_DUMP       = 4'd9
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_BAD_POS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_INS_WR,
		S_COMPACT,
		S_LOCATE,
		S_DUMP,
		S_REPORT
	} state_t;

	typedef struct packed {
		status_t              status;
		logic [LEN_OUT_W-1:0] length;
		logic                 has_item;
		logic [POS_W-1:0]     item_index;
		logic [VALUE_W-1:0]   item_value;
		logic                 last;
	} result_t;

endpackage

// ===== design/ordered_list_insert_delete_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core
// Packed ordered list of signed 32-bit entries with insert/remove requests.
// ----------------------------------------------------------------------------
// Result items are registered. Append, insert and prepend add a write state
//   after the shift pass; a pass over the entries reads them through the
//   registered read port of the element store.
// Requests: one at a time, busy until done; a pass is paced by the single
//   read port of the element store (one entry a cycle).
// Reset: arst_n clears the length and the sequencer; stored entries are not
//   cleared. Result items cannot be stalled by the receiver.
module ordered_list_insert_delete_core import olid_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [3:0]                req_type,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [POS_W-1:0]          position,
	input  logic [POS_W-1:0]          position_end,
	output logic                      busy,
	output logic                      result_valid,
	output logic [1:0]                status,
	output logic [LEN_OUT_W-1:0]      length,
	output logic                      has_item,
	output logic [POS_W-1:0]          item_index,
	output logic signed [VALUE_W-1:0] item_value,
	output logic                      last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// element store port
	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [VALUE_W-1:0] mem_wdata, mem_rdata;

	result_t res;

	// Sequencer: decodes each item, runs the shift, compaction or scan pass
	// over the store, and registers every result item for one cycle.
	olid_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.value        (value),
		.position     (position),
		.position_end (position_end),
		.busy         (busy),
		.res_vld      (result_valid),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	// Element store: reads run ahead of writes during a pass, so a write
	// never targets the entry being read in the same cycle.
	olid_mem #(
		.DEPTH (CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// unpack the registered result item onto the ports
	assign status     = res.status;
	assign length     = res.length;
	assign has_item   = res.has_item;
	assign item_index = res.item_index;
	assign item_value = res.item_value;
	assign last       = res.last;

endmodule

// ===== design/olid_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olid_mem import olid_pkg::*; #(
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/olid_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_ctrl
// Request sequencer: decodes a request, walks the element store through
// read-modify-write passes and produces the result items.
// ----------------------------------------------------------------------------
module olid_ctrl import olid_pkg::*; #(
	parameter int CAPACITY = 32,
	localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [3:0]                req_type,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [POS_W-1:0]          position,
	input  logic [POS_W-1:0]          position_end,
	output logic                      busy,
	output logic                      res_vld,
	output result_t                   res,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [VALUE_W-1:0]        mem_wdata,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_raddr,
	input  logic [VALUE_W-1:0]        mem_rdata
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W) ? LW + 1 : POS_W + 1;
	localparam int HW = $clog2(MAX_RESULTS + 1);

	state_t             state_q, state_d;
	logic [LW-1:0]      len_q;
	logic [CW-1:0]      rem_q, rd_q, wr_q, ins_q;
	logic [CW-1:0]      wa_s1, idx_s1, pend_idx_q;
	logic [VALUE_W-1:0] val_q;
	logic               ins_op_q, up_q, vld_s1, last_s1, pend_q;
	status_t            status_q;
	logic [HW-1:0]      hits_q;
	logic               res_vld_q;
	result_t            res_q;

	req_t          req;
	logic [CW-1:0] len_w, pos_w, pe_w, ins_pos;
	logic          empty, full;
	state_t        dec_state;
	status_t       dec_status;
	logic [CW-1:0] dec_rem, dec_rd, dec_wr, dec_len;
	logic          dec_up, dec_ins_op;

	logic    acc, issue, match, stop, scan_end, emit;
	result_t emit_res;

	assign acc      = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign match    = (mem_rdata == val_q);
	assign scan_end = (rem_q == '0) && !vld_s1;
	assign issue    = ((state_q == S_MOVE) || (state_q == S_COMPACT) ||
	                   (state_q == S_LOCATE) || (state_q == S_DUMP)) && (rem_q != '0);
	assign stop     = (state_q == S_LOCATE) && vld_s1 && match &&
	                  (HW'(hits_q + 1'b1) == HW'(MAX_RESULTS));

	// request decode, evaluated while idle
	always_comb begin
		req   = req_t'(req_type);
		len_w = CW'(len_q);
		pos_w = CW'(position);
		pe_w  = CW'(position_end);
		empty = (len_q == '0);
		full  = (len_w == CW'(CAPACITY));
		if (req == REQ_APPEND) begin
			ins_pos = len_w;
		end else if (req == REQ_INSERT) begin
			ins_pos = pos_w;
		end else begin
			ins_pos = '0;
		end
		dec_state  = S_REPORT;
		dec_status = ST_OK;
		dec_rem    = '0;
		dec_rd     = '0;
		dec_wr     = '0;
		dec_up     = 1'b0;
		dec_len    = len_w;
		dec_ins_op = 1'b0;
		unique case (req)
			REQ_APPEND, REQ_INSERT, REQ_PREPEND: begin
				dec_ins_op = 1'b1;
				if (full) begin
					dec_status = ST_FULL;
				end else if (ins_pos > len_w) begin
					dec_status = ST_BAD_POS;
				end else begin
					dec_state = S_MOVE;
					dec_rem   = len_w - ins_pos;
					dec_rd    = len_w - 1'b1;
					dec_wr    = len_w;
					dec_up    = 1'b1;
					dec_len   = len_w + 1'b1;
				end
			end
			REQ_DROP_FIRST: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state = S_MOVE;
					dec_rem   = len_w - 1'b1;
					dec_rd    = CW'(1);
					dec_len   = len_w - 1'b1;
				end
			end
			REQ_DROP_LAST: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_len = len_w - 1'b1;
				end
			end
			REQ_DROP_AT: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else if (pos_w >= len_w) begin
					dec_status = ST_BAD_POS;
				end else begin
					dec_state = S_MOVE;
					dec_rem   = len_w - pos_w - 1'b1;
					dec_rd    = pos_w + 1'b1;
					dec_wr    = pos_w;
					dec_len   = len_w - 1'b1;
				end
			end
			REQ_DROP_VALUE: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state = S_COMPACT;
					dec_rem   = len_w;
				end
			end
			REQ_LOCATE: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state = S_LOCATE;
					dec_rem   = len_w;
				end
			end
			REQ_DROP_RANGE: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else if ((pos_w >= len_w) || (pe_w < pos_w) || (pe_w >= len_w)) begin
					dec_status = ST_BAD_POS;
				end else begin
					dec_state = S_MOVE;
					dec_rem   = len_w - pe_w - 1'b1;
					dec_rd    = pe_w + 1'b1;
					dec_wr    = pos_w;
					dec_len   = len_w - pe_w + pos_w - 1'b1;
				end
			end
			REQ_DUMP: begin
				if (!empty) begin
					dec_state = S_DUMP;
					dec_rem   = (len_w > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : len_w;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = dec_state;
				end
			end
			S_MOVE: begin
				if (scan_end) begin
					state_d = ins_op_q ? S_INS_WR : S_REPORT;
				end
			end
			S_INS_WR: state_d = S_REPORT;
			S_COMPACT: begin
				if (scan_end) begin
					state_d = S_REPORT;
				end
			end
			S_LOCATE, S_DUMP: begin
				if (scan_end) begin
					state_d = S_IDLE;
				end
			end
			S_REPORT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory controls and result items
	always_comb begin
		mem_re              = issue;
		mem_raddr           = rd_q[AW-1:0];
		mem_we              = 1'b0;
		mem_waddr           = wa_s1[AW-1:0];
		mem_wdata           = mem_rdata;
		emit                = 1'b0;
		emit_res.status     = ST_OK;
		emit_res.length     = LEN_OUT_W'(len_q);
		emit_res.has_item   = 1'b0;
		emit_res.item_index = '0;
		emit_res.item_value = '0;
		emit_res.last       = 1'b1;
		unique case (state_q)
			S_MOVE: mem_we = vld_s1;
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = ins_q[AW-1:0];
				mem_wdata = val_q;
			end
			S_COMPACT: begin
				mem_we    = vld_s1 && !match;
				mem_waddr = wr_q[AW-1:0];
			end
			S_LOCATE: begin
				if (vld_s1 && match && pend_q) begin
					emit                = 1'b1;
					emit_res.has_item   = 1'b1;
					emit_res.item_index = POS_W'(pend_idx_q);
					emit_res.item_value = val_q;
					emit_res.last       = 1'b0;
				end else if (scan_end) begin
					emit                = 1'b1;
					emit_res.has_item   = pend_q;
					emit_res.item_index = pend_q ? POS_W'(pend_idx_q) : '0;
					emit_res.item_value = pend_q ? val_q : '0;
				end
			end
			S_DUMP: begin
				if (vld_s1) begin
					emit                = 1'b1;
					emit_res.has_item   = 1'b1;
					emit_res.item_index = POS_W'(idx_s1);
					emit_res.item_value = mem_rdata;
					emit_res.last       = last_s1;
				end
			end
			S_REPORT: begin
				emit            = 1'b1;
				emit_res.status = status_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			len_q     <= '0;
			rem_q     <= '0;
			vld_s1    <= 1'b0;
			pend_q    <= 1'b0;
			hits_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_vld_q <= emit;
			vld_s1    <= issue && !stop;
			if (acc) begin
				len_q  <= LW'(dec_len);
				rem_q  <= dec_rem;
				pend_q <= 1'b0;
				hits_q <= '0;
			end else begin
				if (stop) begin
					rem_q <= '0;
				end else if (issue) begin
					rem_q <= rem_q - 1'b1;
				end
				if ((state_q == S_COMPACT) && scan_end) begin
					len_q <= LW'(wr_q);
				end
				if ((state_q == S_LOCATE) && vld_s1 && match) begin
					pend_q <= 1'b1;
					hits_q <= hits_q + 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			ins_op_q <= dec_ins_op;
			val_q    <= value;
			ins_q    <= ins_pos;
			rd_q     <= dec_rd;
			wr_q     <= dec_wr;
			up_q     <= dec_up;
			status_q <= dec_status;
		end else begin
			if (issue) begin
				wa_s1   <= wr_q;
				idx_s1  <= rd_q;
				last_s1 <= (rem_q == CW'(1));
				rd_q    <= up_q ? rd_q - 1'b1 : rd_q + 1'b1;
				if (state_q == S_MOVE) begin
					wr_q <= up_q ? wr_q - 1'b1 : wr_q + 1'b1;
				end
			end
			if ((state_q == S_COMPACT) && vld_s1 && !match) begin
				wr_q <= wr_q + 1'b1;
			end
			if ((state_q == S_LOCATE) && vld_s1 && match) begin
				pend_idx_q <= idx_s1;
			end
		end
		if (emit) begin
			res_q <= emit_res;
		end
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule

// ===== bench/ordered_list_insert_delete_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core_tb
// Self-checking bench for the ordered list core. A shadow list predicts the
// result items of every accepted request. The monitor checks each strobed
// result against the oldest prediction. Stimulus starts with a directed
// sequence of corner requests. It then alternates grow and shrink phases with
// random content, so the list swings between empty and full.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core_tb import olid_pkg::*;;

	localparam int          LIST_DEPTH      = 32;
	localparam int          RANDOM_ITEMS    = 350;
	localparam int          WATCHDOG_CYCLES = 4000;
	localparam int          DRAIN_CYCLES    = 80;
	localparam int          PHASE_MAX_ITEMS = 150;
	localparam logic [3:0]  REQ_FIRST_UNUSED = 4'd10;
	localparam logic [3:0]  REQ_CODE_MAX     = 4'd15;
	localparam logic [31:0] SIGNED_MIN       = 32'h8000_0000;
	localparam logic [31:0] SIGNED_MAX       = 32'h7fff_ffff;
	localparam logic [31:0] ALL_ONES         = 32'hffff_ffff;
	localparam logic [31:0] STRIPES          = 32'h5a5a_a5a5;

	// One request as the driver presents it.
	typedef struct {
		logic [3:0]         kind;
		logic [VALUE_W-1:0] data;
		logic [POS_W-1:0]   pos;
		logic [POS_W-1:0]   pos_end;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Block inputs start at known values and change only at rising edges.
	logic                      start = 1'b0;
	logic [3:0]                req_type = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic [POS_W-1:0]          position = '0;
	logic [POS_W-1:0]          position_end = '0;

	logic                      busy;
	logic                      result_valid;
	logic [1:0]                status;
	logic [LEN_OUT_W-1:0]      length;
	logic                      has_item;
	logic [POS_W-1:0]          item_index;
	logic signed [VALUE_W-1:0] item_value;
	logic                      last;

	ordered_list_insert_delete_core #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req_type),
		.value(value),
		.position(position),
		.position_end(position_end),
		.busy(busy),
		.result_valid(result_valid),
		.status(status),
		.length(length),
		.has_item(has_item),
		.item_index(item_index),
		.item_value(item_value),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow list and the result items it predicts
	// ------------------------------------------------------------------
	logic [VALUE_W-1:0] shadow_list [LIST_DEPTH];
	int unsigned        shadow_len = 0;
	result_t            due_results [$];
	request_t           request_q [$];

	int unsigned accepted_items = 0;
	int unsigned issued_items = 0;
	int unsigned full_refusals = 0;
	int unsigned empty_refusals = 0;
	int unsigned error_count = 0;

	function automatic void expect_result(status_t st, logic has, int unsigned idx,
			logic [VALUE_W-1:0] val, logic fin);
		result_t r;
		r.status     = st;
		r.length     = LEN_OUT_W'(shadow_len);
		r.has_item   = has;
		r.item_index = POS_W'(idx);
		r.item_value = val;
		r.last       = fin;
		due_results.push_back(r);
		if (st == ST_FULL)
			full_refusals++;
		if (st == ST_EMPTY)
			empty_refusals++;
	endfunction

	// Insert with the full check ahead of the position check.
	function automatic status_t insert_entry(int unsigned at, logic [VALUE_W-1:0] v);
		if (shadow_len >= LIST_DEPTH)
			return ST_FULL;
		if (at > shadow_len)
			return ST_BAD_POS;
		for (int unsigned i = shadow_len; i > at; i--)
			shadow_list[i] = shadow_list[i-1];
		shadow_list[at] = v;
		shadow_len++;
		return ST_OK;
	endfunction

	// Close the gap of count entries at first; the tail moves down.
	function automatic void close_gap(int unsigned first, int unsigned count);
		for (int unsigned i = first; i + count < shadow_len; i++)
			shadow_list[i] = shadow_list[i+count];
		shadow_len -= count;
	endfunction

	// Apply one accepted request to the shadow list and queue its results.
	function automatic void run_list_request(request_t rq);
		status_t     st;
		int unsigned wr;
		int unsigned hits;
		int unsigned seen;
		st = ST_OK;
		case (rq.kind)
			REQ_APPEND:  st = insert_entry(shadow_len, rq.data);
			REQ_INSERT:  st = insert_entry(rq.pos, rq.data);
			REQ_PREPEND: st = insert_entry(0, rq.data);
			REQ_DROP_FIRST: begin
				if (shadow_len == 0)
					st = ST_EMPTY;
				else
					close_gap(0, 1);
			end
			REQ_DROP_LAST: begin
				if (shadow_len == 0)
					st = ST_EMPTY;
				else
					shadow_len--;
			end
			REQ_DROP_AT: begin
				if (shadow_len == 0)
					st = ST_EMPTY;
				else if (rq.pos >= shadow_len)
					st = ST_BAD_POS;
				else
					close_gap(rq.pos, 1);
			end
			REQ_DROP_VALUE: begin
				if (shadow_len == 0) begin
					st = ST_EMPTY;
				end else begin
					wr = 0;
					for (int unsigned i = 0; i < shadow_len; i++)
						if (shadow_list[i] != rq.data) begin
							shadow_list[wr] = shadow_list[i];
							wr++;
						end
					shadow_len = wr;
				end
			end
			REQ_LOCATE: begin
				if (shadow_len == 0) begin
					st = ST_EMPTY;
				end else begin
					hits = 0;
					for (int unsigned i = 0; i < shadow_len; i++)
						if (shadow_list[i] == rq.data)
							hits++;
					if (hits > MAX_RESULTS)
						hits = MAX_RESULTS;
					seen = 0;
					for (int unsigned i = 0; i < shadow_len && seen < hits; i++)
						if (shadow_list[i] == rq.data) begin
							seen++;
							expect_result(ST_OK, 1'b1, i, rq.data, seen == hits);
						end
					if (hits != 0)
						return;
				end
			end
			REQ_DROP_RANGE: begin
				if (shadow_len == 0)
					st = ST_EMPTY;
				else if (rq.pos >= shadow_len || rq.pos_end < rq.pos ||
						rq.pos_end >= shadow_len)
					st = ST_BAD_POS;
				else
					close_gap(rq.pos, rq.pos_end - rq.pos + 1);
			end
			REQ_DUMP: begin
				hits = (shadow_len > MAX_RESULTS) ? MAX_RESULTS : shadow_len;
				for (int unsigned i = 0; i < hits; i++)
					expect_result(ST_OK, 1'b1, i, shadow_list[i], i + 1 == hits);
				if (hits != 0)
					return;
			end
			default: st = ST_OK;
		endcase
		expect_result(st, 1'b0, 0, '0, 1'b1);
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of requests separated by random gaps
	// ------------------------------------------------------------------
	request_t    live_req;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		request_t nxt;
		logic     hold;
		if (arst_n) begin
			// Hold the current item while the block refuses it.
			hold = start && busy;
			if (start && !busy) begin
				run_list_request(live_req);
				accepted_items++;
			end
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (request_q.size() > 0) begin
					nxt = request_q.pop_front();
					live_req = nxt;
					start        <= 1'b1;
					req_type     <= nxt.kind;
					value        <= nxt.data;
					position     <= nxt.pos;
					position_end <= nxt.pos_end;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// Mix back-to-back stretches with short and long pauses.
						case ($urandom_range(0, 5))
							0, 1:    gap_left = 0;
							2, 3:    gap_left = $urandom_range(1, 6);
							4:       gap_left = $urandom_range(7, 20);
							default: gap_left = $urandom_range(21, 45);
						endcase
						burst_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(30, 60) : $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every strobed result is checked against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0d length %0d has_item %0d index %0d",
					status, length, has_item, item_index);
				error_count++;
			end else begin
				want = due_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					error_count++;
				end
				if (length !== want.length) begin
					$error("length: expected %0d, actual %0d", want.length, length);
					error_count++;
				end
				if (has_item !== want.has_item) begin
					$error("has_item: expected %0d, actual %0d", want.has_item, has_item);
					error_count++;
				end
				if (item_index !== want.item_index) begin
					$error("item_index: expected %0d, actual %0d",
						want.item_index, item_index);
					error_count++;
				end
				if (item_value !== want.item_value) begin
					$error("item_value: expected %0d, actual %0d",
						$signed(want.item_value), item_value);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run when nothing moves for too long
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return SIGNED_MIN;
			1:       return SIGNED_MAX;
			2:       return '0;
			3:       return ALL_ONES;
			4:       return STRIPES;
			5:       return 32'd1;
			default: return $urandom();
		endcase
	endfunction

	// Favor values already in the list so that drop value and locate hit.
	function automatic logic [VALUE_W-1:0] pick_stored_value();
		if (shadow_len > 0 && $urandom_range(0, 9) < 7)
			return shadow_list[$urandom_range(0, shadow_len - 1)];
		return pick_value();
	endfunction

	function automatic logic [POS_W-1:0] pos_inside(int unsigned len);
		return (len == 0) ? '0 : POS_W'($urandom_range(0, len - 1));
	endfunction

	function automatic logic [POS_W-1:0] pos_outside(int unsigned len);
		return (len >= LIST_DEPTH) ? POS_W'($urandom()) :
			POS_W'($urandom_range(len, LIST_DEPTH - 1));
	endfunction

	function automatic request_t make_request(request_t base, logic [3:0] kind,
			logic [VALUE_W-1:0] data, logic [POS_W-1:0] pos, logic [POS_W-1:0] pos_end);
		request_t r;
		r = base;
		r.kind    = kind;
		r.data    = data;
		r.pos     = pos;
		r.pos_end = pos_end;
		return r;
	endfunction

	// Build a well-formed range inside a non-empty list, mostly short ones.
	function automatic request_t make_range(request_t base, int unsigned len);
		request_t    r;
		int unsigned first;
		int unsigned span;
		r = base;
		r.kind = REQ_DROP_RANGE;
		first = pos_inside(len);
		span = (len == 0) ? 0 : len - 1 - first;
		if ($urandom_range(0, 4) != 0 && span > 3)
			span = $urandom_range(0, 3);
		else if (span > 0)
			span = $urandom_range(0, span);
		r.pos     = POS_W'(first);
		r.pos_end = POS_W'(first + span);
		return r;
	endfunction

	function automatic request_t make_random_request(logic growing);
		request_t    r;
		int unsigned len;
		int unsigned sel;
		r.kind    = REQ_DUMP;
		r.data    = $urandom();
		r.pos     = POS_W'($urandom());
		r.pos_end = POS_W'($urandom());
		len = shadow_len;
		sel = $urandom_range(0, 99);
		if (sel >= 96) begin
			// Noise: any code, unknown ones included, and raw fields.
			r.kind = ($urandom_range(0, 1) == 0) ?
				4'($urandom_range(REQ_FIRST_UNUSED, REQ_CODE_MAX)) : 4'($urandom());
		end else if (growing) begin
			if (sel < 30)
				r = make_request(r, REQ_APPEND, pick_value(), r.pos, r.pos_end);
			else if (sel < 45)
				r = make_request(r, REQ_PREPEND, pick_value(), r.pos, r.pos_end);
			else if (sel < 65)
				r = make_request(r, REQ_INSERT, pick_value(),
					(len >= LIST_DEPTH) ? POS_W'($urandom()) : POS_W'($urandom_range(0, len)),
					r.pos_end);
			else if (sel < 70)
				r = make_request(r, REQ_INSERT, pick_value(),
					(len + 1 >= LIST_DEPTH) ? POS_W'($urandom()) :
					POS_W'($urandom_range(len + 1, LIST_DEPTH - 1)), r.pos_end);
			else if (sel < 78)
				r = make_request(r, REQ_LOCATE, pick_stored_value(), r.pos, r.pos_end);
			else if (sel < 83)
				r.kind = REQ_DUMP;
			else if (sel < 88)
				r = make_request(r, REQ_DROP_AT, r.data, pos_inside(len), r.pos_end);
			else if (sel < 92)
				r = make_request(r, REQ_DROP_VALUE, pick_stored_value(), r.pos, r.pos_end);
			else if (sel < 94)
				r = make_range(r, len);
			else
				r.kind = ($urandom_range(0, 1) == 0) ? REQ_DROP_FIRST : REQ_DROP_LAST;
		end else begin
			if (sel < 15)
				r.kind = REQ_DROP_FIRST;
			else if (sel < 30)
				r.kind = REQ_DROP_LAST;
			else if (sel < 45)
				r = make_request(r, REQ_DROP_AT, r.data, pos_inside(len), r.pos_end);
			else if (sel < 50)
				r = make_request(r, REQ_DROP_AT, r.data, pos_outside(len), r.pos_end);
			else if (sel < 60)
				r = make_request(r, REQ_DROP_VALUE, pick_stored_value(), r.pos, r.pos_end);
			else if (sel < 70)
				r = make_range(r, len);
			else if (sel < 75)
				r.kind = REQ_DROP_RANGE;
			else if (sel < 82)
				r = make_request(r, REQ_LOCATE, pick_stored_value(), r.pos, r.pos_end);
			else if (sel < 88)
				r.kind = REQ_DUMP;
			else
				r = make_request(r, ($urandom_range(0, 1) == 0) ? REQ_APPEND : REQ_INSERT,
					pick_value(), POS_W'($urandom_range(0, (len < LIST_DEPTH) ? len : 0)),
					r.pos_end);
		end
		return r;
	endfunction

	function automatic void queue_request(logic [3:0] kind, logic [VALUE_W-1:0] data,
			logic [POS_W-1:0] pos, logic [POS_W-1:0] pos_end);
		request_t r;
		r.kind    = kind;
		r.data    = data;
		r.pos     = pos;
		r.pos_end = pos_end;
		request_q.push_back(r);
		issued_items++;
	endfunction

	initial begin
		logic        growing;
		int unsigned phase_items;
		int unsigned full_mark;
		int unsigned empty_mark;

		// Directed part: every drop, locate and dump request on the empty list first.
		queue_request(REQ_DROP_FIRST, '0, '0, '0);
		queue_request(REQ_DROP_LAST, '0, '0, '0);
		queue_request(REQ_DROP_AT, '0, '0, '0);
		queue_request(REQ_DROP_VALUE, '0, '0, '0);
		queue_request(REQ_LOCATE, '0, '0, '0);
		queue_request(REQ_DROP_RANGE, '0, '0, '0);
		queue_request(REQ_DUMP, '0, '0, '0);
		queue_request(REQ_INSERT, STRIPES, 5'd1, '0);        // position past the end
		queue_request(REQ_CODE_MAX, ALL_ONES, 5'd31, 5'd31);  // unknown code
		// Build [MIN, 0, MAX, -1, MIN] with every kind of insert.
		queue_request(REQ_APPEND, SIGNED_MAX, '0, '0);
		queue_request(REQ_PREPEND, SIGNED_MIN, '0, '0);
		queue_request(REQ_INSERT, '0, 5'd1, '0);
		queue_request(REQ_INSERT, ALL_ONES, 5'd3, '0);        // at the end position
		queue_request(REQ_APPEND, SIGNED_MIN, '0, '0);
		queue_request(REQ_LOCATE, SIGNED_MIN, '0, '0);        // two matches
		queue_request(REQ_LOCATE, STRIPES, '0, '0);           // no match
		queue_request(REQ_DROP_AT, '0, 5'd31, '0);            // out of range
		queue_request(REQ_DROP_RANGE, '0, 5'd2, 5'd1);        // end below start
		queue_request(REQ_DROP_RANGE, '0, 5'd1, 5'd31);       // end past the list
		queue_request(REQ_DROP_VALUE, STRIPES, '0, '0);       // nothing to drop
		queue_request(REQ_DROP_RANGE, '0, 5'd1, 5'd2);
		queue_request(REQ_DUMP, '0, '0, '0);
		queue_request(REQ_DROP_VALUE, SIGNED_MIN, '0, '0);
		queue_request(REQ_DUMP, '0, '0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Random part: alternate grow and shrink phases. Each phase ends after three
		// refusals at full or empty (so both limits get hit), past PHASE_MAX_ITEMS items or at random.
		growing = 1'b1;
		phase_items = 0;
		full_mark = full_refusals;
		empty_mark = empty_refusals;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Keep the queue short so that choices track the list closely.
			while (request_q.size() != 0)
				@(posedge clk);
			if (growing && (full_refusals - full_mark >= 3 || phase_items > PHASE_MAX_ITEMS ||
					$urandom_range(0, 99) == 0)) begin
				growing = 1'b0;
				phase_items = 0;
				empty_mark = empty_refusals;
			end else if (!growing && (empty_refusals - empty_mark >= 3 ||
					phase_items > PHASE_MAX_ITEMS || $urandom_range(0, 99) == 0)) begin
				growing = 1'b1;
				phase_items = 0;
				full_mark = full_refusals;
			end
			request_q.push_back(make_random_request(growing));
			issued_items++;
			phase_items++;
		end

		// Drain, then give stray result items time to show.
		while (accepted_items < issued_items || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (due_results.size() != 0) begin
			$error("%0d result items never arrived", due_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/olid_pkg.sv
design/olid_mem.sv
design/olid_ctrl.sv
design/ordered_list_insert_delete_core.sv
bench/ordered_list_insert_delete_core_tb.sv
